FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// shared widths, types and defaults for the lfu page replacement block
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int PAGE_W      = 8;
  localparam int FRAME_W     = 4;
  localparam int USE_W       = 16;
  localparam int FRAMES_DEF  = 4;
  localparam int COUNT_W_DEF = 16;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [USE_W-1:0]   use_t;

  localparam page_t PAGE_EMPTY = '0;

endpackage

FILE: hdl/lfu_frames.sv
// ----------------------------------------------------------------------------
// lfu_frames
// frame table: resident page and use count per frame, one read and one
// write port, cleared to empty at reset
// ----------------------------------------------------------------------------
module lfu_frames
  import lfu_pkg::*;
#(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int COUNT_WIDTH = COUNT_W_DEF,
  localparam int IDX_W      = $clog2(FRAMES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IDX_W-1:0]       rd_idx,
  output page_t                  rd_page,
  output logic [COUNT_WIDTH-1:0] rd_count,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_idx,
  input  page_t                  wr_page,
  input  logic [COUNT_WIDTH-1:0] wr_count
);

  page_t                  frame_page  [FRAMES];
  logic [COUNT_WIDTH-1:0] frame_count [FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i]  <= PAGE_EMPTY;
        frame_count[i] <= '0;
      end
    end else if (wr_en) begin
      frame_page[wr_idx]  <= wr_page;
      frame_count[wr_idx] <= wr_count;
    end
  end

  assign rd_page  = frame_page[rd_idx];
  assign rd_count = frame_count[rd_idx];

endmodule

FILE: hdl/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// least-frequently-used page replacement over a small set of frames
// a reference scans the frame table in order, stopping early on a hit, then takes
// a final update step; page zero reports done in the cycle after start
// a new reference is accepted only when idle, so start is ignored during the one-frame-per-
// cycle scan through the frame table and the final update step
// reset: all frames empty with zero counts; results cannot be stalled
// ----------------------------------------------------------------------------
module lfu_page_replacement
  import lfu_pkg::*;
#(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  page_t  page,
  output logic   busy,
  output logic   done,
  output logic   hit,
  output frame_t frame,
  output page_t  evicted_page,
  output use_t   use_count
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAMES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]             state;
  page_t                  pg;
  logic [IDX_W-1:0]       idx;
  logic                   hit_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [COUNT_WIDTH-1:0] hit_cnt;
  logic                   empty_found;
  logic [IDX_W-1:0]       empty_idx;
  logic [IDX_W-1:0]       best_idx;
  logic [COUNT_WIDTH-1:0] best_cnt;
  page_t                  best_page;

  page_t                  rd_page;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [COUNT_WIDTH-1:0] wr_count;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   better;
  logic [31:0]            cnt_wide;

  lfu_frames #(
    .FRAMES      (FRAMES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_frames (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx),
    .rd_page  (rd_page),
    .rd_count (rd_count),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_page  (pg),
    .wr_count (wr_count)
  );

  assign busy = (state != ST_IDLE);

  // scan compare: lower count wins, ties to the smaller page
  assign better = (rd_count < best_cnt) || ((rd_count == best_cnt) && (rd_page < best_page));

  assign cnt_inc = (hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_WIDTH'(1);

  always_comb begin
    wr_en    = (state == ST_UPDATE);
    wr_idx   = best_idx;
    wr_count = COUNT_WIDTH'(1);
    if (hit_found) begin
      wr_idx   = hit_idx;
      wr_count = cnt_inc;
    end else if (empty_found) begin
      wr_idx = empty_idx;
    end
  end

  assign cnt_wide = 32'(wr_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      idx         <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            pg          <= page;
            idx         <= '0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            if (page == PAGE_EMPTY) begin
              done         <= 1'b1;
              hit          <= 1'b0;
              frame        <= '0;
              evicted_page <= PAGE_EMPTY;
              use_count    <= '0;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (idx == '0 || better) begin
            best_idx  <= idx;
            best_cnt  <= rd_count;
            best_page <= rd_page;
          end
          if (rd_page == PAGE_EMPTY && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= idx;
          end
          if (rd_page == pg) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
            hit_cnt   <= rd_count;
            state     <= ST_UPDATE;
          end else if (idx == IDX_LAST) begin
            state <= ST_UPDATE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_UPDATE: begin
          state        <= ST_IDLE;
          done         <= 1'b1;
          hit          <= hit_found;
          frame        <= FRAME_W'(wr_idx);
          evicted_page <= (hit_found || empty_found) ? PAGE_EMPTY : best_page;
          use_count    <= cnt_wide[USE_W-1:0];
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result strobe only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted reference either starts a scan or answers at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted reference dropped");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (evicted_page == PAGE_EMPTY))
    else $error("hit reported an eviction");

  // no result without a transfer or a scan behind it
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("spurious result");

endmodule
